>>> src/vis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vis_pkg - vehicle interface supervisor definitions
// Shared codes, item and register types for the supervisor and its step logic.
// ----------------------------------------------------------------------------
package vis_pkg;

    localparam int unsigned SecsW   = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 16;
    localparam int unsigned InDataW = 24;
    localparam int unsigned OutDataW = 8;

    localparam logic        RstHelmRequired = 1'b1;
    localparam logic [SecsW-1:0] RstHelmTimeout = 16'd10;
    localparam logic [SecsW-1:0] RstLinkTimeout = 16'd10;

    typedef enum logic [2:0] {
        ST_STANDBY  = 3'd0,
        ST_LISTEN   = 3'd1,
        ST_COMMAND  = 3'd2,
        ST_HELM_ERR = 3'd3,
        ST_LINK_ERR = 3'd4
    } t_sup_state;

    typedef enum logic [1:0] {
        HM_NOT_RUNNING = 2'd0,
        HM_DRIVE       = 2'd1,
        HM_PARK        = 2'd2
    } t_helm_mode;

    typedef enum logic [1:0] {
        VM_NOT_CONNECTED = 2'd0,
        VM_IDLE          = 2'd1,
        VM_ACCEPTING     = 2'd2,
        VM_IN_CONTROL    = 2'd3
    } t_veh_mode;

    typedef enum logic [1:0] {
        HF_NONE        = 2'd0,
        HF_PARKED      = 2'd1,
        HF_NOT_RUNNING = 2'd2
    } t_helm_fault;

    typedef enum logic [1:0] {
        LF_NONE          = 2'd0,
        LF_NOT_CONNECTED = 2'd1,
        LF_NO_DATA       = 2'd2
    } t_link_fault;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_HELM_REQUIRED = 2'd0,
        CFG_HELM_TIMEOUT  = 2'd1,
        CFG_LINK_TIMEOUT  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [SecsW-1:0] elapsed_seconds;
        logic             data_present;
        logic [1:0]       vehicle_mode;
        logic [1:0]       helm_mode;
    } t_item;

    typedef struct packed {
        logic             helm_required;
        logic [SecsW-1:0] helm_timeout_seconds;
        logic [SecsW-1:0] link_timeout_seconds;
    } t_cfg;

    typedef struct packed {
        t_sup_state  state;
        t_helm_fault helm_fault;
        t_link_fault link_fault;
    } t_sup_ctx;

endpackage

>>> src/vis_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vis_step - supervisor step rule
// Combinational next state and fault codes for one poll item.
// ----------------------------------------------------------------------------
module vis_step (
    input  vis_pkg::t_sup_ctx i_cur,
    input  vis_pkg::t_item    i_item,
    input  vis_pkg::t_cfg     i_cfg,
    output vis_pkg::t_sup_ctx o_next
);
    import vis_pkg::*;

    logic w_helm_park;
    logic w_helm_nr_err;
    logic w_link_nc_err;
    logic w_no_data_err;
    logic w_cmd_ok;
    logic w_to_listen;
    logic w_link_clear;
    t_sup_ctx w_faulted;

    assign w_helm_park   = (i_item.helm_mode == HM_PARK);
    assign w_helm_nr_err = i_cfg.helm_required && (i_item.helm_mode == HM_NOT_RUNNING) &&
                           ((i_cur.state == ST_COMMAND) ||
                            (i_item.elapsed_seconds > i_cfg.helm_timeout_seconds));
    assign w_link_nc_err = (i_item.vehicle_mode == VM_NOT_CONNECTED) &&
                           ((i_cur.state != ST_STANDBY) ||
                            (i_item.elapsed_seconds > i_cfg.link_timeout_seconds));
    assign w_no_data_err = !i_item.data_present && (i_cur.state != ST_STANDBY);
    assign w_cmd_ok      = (i_item.vehicle_mode == VM_ACCEPTING) &&
                           ((i_item.helm_mode == HM_DRIVE) || !i_cfg.helm_required);
    assign w_to_listen   = (i_item.vehicle_mode == VM_IN_CONTROL) ||
                           (i_item.vehicle_mode == VM_IDLE);
    assign w_link_clear  = ((i_cur.link_fault == LF_NOT_CONNECTED) &&
                            (i_item.vehicle_mode != VM_NOT_CONNECTED)) ||
                           ((i_cur.link_fault == LF_NO_DATA) && i_item.data_present);

    // outcome of the fault check, helm errors first
    always_comb begin
        w_faulted = i_cur;
        if (w_helm_park) begin
            w_faulted.state      = ST_HELM_ERR;
            w_faulted.helm_fault = HF_PARKED;
        end else if (w_helm_nr_err) begin
            w_faulted.state      = ST_HELM_ERR;
            w_faulted.helm_fault = HF_NOT_RUNNING;
        end else if (w_link_nc_err) begin
            w_faulted.state      = ST_LINK_ERR;
            w_faulted.link_fault = LF_NOT_CONNECTED;
        end else if (w_no_data_err) begin
            w_faulted.state      = ST_LINK_ERR;
            w_faulted.link_fault = LF_NO_DATA;
        end
    end

    always_comb begin
        o_next = i_cur;
        unique case (i_cur.state)
            ST_STANDBY: begin
                if (i_item.data_present) o_next.state = ST_LISTEN;
                else                     o_next = w_faulted;
            end
            ST_LISTEN: begin
                if (w_cmd_ok) o_next.state = ST_COMMAND;
                else          o_next = w_faulted;
            end
            ST_COMMAND: begin
                if (w_to_listen) o_next.state = ST_LISTEN;
                else             o_next = w_faulted;
            end
            ST_HELM_ERR: begin
                if (i_item.helm_mode == HM_DRIVE) begin
                    o_next.state      = ST_STANDBY;
                    o_next.helm_fault = HF_NONE;
                end
            end
            ST_LINK_ERR: begin
                if (w_link_clear) begin
                    o_next.state      = ST_STANDBY;
                    o_next.link_fault = LF_NONE;
                end
            end
            default: o_next.state = ST_STANDBY;
        endcase
    end

endmodule

>>> src/vehicle_interface_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_interface_supervisor - polled vehicle interface supervisor
// Five-state supervisor with helm and frontseat fault tracking.
// ----------------------------------------------------------------------------
// path: input register on accept, then result register on advance
// throughput: one item per cycle unless the output stalls; the state
// register updates in the same cycle the result register loads, so
// back-to-back items see fresh state
// reset: synchronous active low; state standby, fault codes none,
// registers at their defaults (helm required, both timeouts 10 s)
module vehicle_interface_supervisor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: helm_mode[1:0], vehicle_mode[3:2], data_present[4],
    // elapsed_seconds[20:5], zero pad[23:21]
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [vis_pkg::InDataW-1:0]   i_s_axis_tdata,
    // tdata: supervisor_state[2:0], state_changed[3], helm_fault[5:4],
    // link_fault[7:6]
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [vis_pkg::OutDataW-1:0]  o_m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vis_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [vis_pkg::CfgDatW-1:0]   i_cfg_data
);
    import vis_pkg::*;

    t_cfg     r_cfg;
    t_sup_ctx r_ctx;
    t_sup_ctx w_next;

    logic     r_in_valid;
    t_item    r_in_item;

    logic     r_out_valid;
    t_sup_ctx r_out_ctx;
    logic     r_out_changed;

    logic     w_out_free;
    logic     w_adv;

    assign o_cfg_ready     = 1'b1;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.helm_required        <= RstHelmRequired;
            r_cfg.helm_timeout_seconds <= RstHelmTimeout;
            r_cfg.link_timeout_seconds <= RstLinkTimeout;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HELM_REQUIRED: r_cfg.helm_required        <= i_cfg_data[0];
                CFG_HELM_TIMEOUT:  r_cfg.helm_timeout_seconds <= i_cfg_data[SecsW-1:0];
                CFG_LINK_TIMEOUT:  r_cfg.link_timeout_seconds <= i_cfg_data[SecsW-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_item <= t_item'(i_s_axis_tdata[$bits(t_item)-1:0]);
        end
    end

    vis_step u_step (
        .i_cur  (r_ctx),
        .i_item (r_in_item),
        .i_cfg  (r_cfg),
        .o_next (w_next)
    );

    // supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state      <= ST_STANDBY;
            r_ctx.helm_fault <= HF_NONE;
            r_ctx.link_fault <= LF_NONE;
        end else if (w_adv) begin
            r_ctx <= w_next;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_ctx     <= w_next;
            r_out_changed <= (w_next.state != r_ctx.state);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_ctx.link_fault, r_out_ctx.helm_fault,
                              r_out_changed, r_out_ctx.state};

    // a helm error always carries its code
    a_helm_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctx.state == ST_HELM_ERR) |-> (r_ctx.helm_fault != HF_NONE))
        else $error("helm error state without a fault code");

    // a frontseat error always carries its code
    a_link_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctx.state == ST_LINK_ERR) |-> (r_ctx.link_fault != LF_NONE))
        else $error("frontseat error state without a fault code");

    // every item leaving the input register lands in the result register
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("item lost between input and result register");

    // the result reports the state the supervisor moved to
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out_ctx == r_ctx))
        else $error("result disagrees with supervisor state");

    // state only moves when an item advances
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_ctx))
        else $error("supervisor state moved without an item");

endmodule

>>> sim/vis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vis_checker - status checker for the vehicle interface supervisor
// Watches the register, poll and status channels and keeps its own copy of
// the supervisor state and registers. Each accepted poll queues the status
// it should produce. Each accepted status is compared field by field with
// the oldest queued entry.
// ----------------------------------------------------------------------------
module vis_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          i_s_axis_tready,
    input  logic [vis_pkg::InDataW-1:0]   i_s_axis_tdata,
    input  logic                          i_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [vis_pkg::OutDataW-1:0]  i_m_axis_tdata,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [vis_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [vis_pkg::CfgDatW-1:0]   i_cfg_data,
    output int                            o_outstanding,
    output int                            o_failures
);
    import vis_pkg::*;

    typedef struct {
        logic [2:0] state;
        logic       changed;
        logic [1:0] helm_fault;
        logic [1:0] link_fault;
    } t_status;

    t_sup_state  sup_state;
    t_helm_fault helm_fault;
    t_link_fault link_fault;
    t_cfg        regs;

    t_status expected_status[$];
    t_status want;
    int      fail_count = 0;

    // helm errors win over frontseat errors
    function automatic void fault_check(input t_item p);
        if (p.helm_mode == HM_PARK) begin
            helm_fault = HF_PARKED;
            sup_state  = ST_HELM_ERR;
        end else if (regs.helm_required && p.helm_mode == HM_NOT_RUNNING &&
                     (sup_state == ST_COMMAND ||
                      p.elapsed_seconds > regs.helm_timeout_seconds)) begin
            helm_fault = HF_NOT_RUNNING;
            sup_state  = ST_HELM_ERR;
        end else if (p.vehicle_mode == VM_NOT_CONNECTED &&
                     (sup_state != ST_STANDBY ||
                      p.elapsed_seconds > regs.link_timeout_seconds)) begin
            link_fault = LF_NOT_CONNECTED;
            sup_state  = ST_LINK_ERR;
        end else if (!p.data_present && sup_state != ST_STANDBY) begin
            link_fault = LF_NO_DATA;
            sup_state  = ST_LINK_ERR;
        end
    endfunction

    function automatic t_status step_supervisor(input t_item p);
        t_sup_state prior;
        t_status    r;
        prior = sup_state;
        case (sup_state)
            ST_STANDBY: begin
                if (p.data_present) sup_state = ST_LISTEN;
                else fault_check(p);
            end
            ST_LISTEN: begin
                if (p.vehicle_mode == VM_ACCEPTING &&
                    (p.helm_mode == HM_DRIVE || !regs.helm_required))
                    sup_state = ST_COMMAND;
                else
                    fault_check(p);
            end
            ST_COMMAND: begin
                if (p.vehicle_mode == VM_IN_CONTROL || p.vehicle_mode == VM_IDLE)
                    sup_state = ST_LISTEN;
                else
                    fault_check(p);
            end
            ST_HELM_ERR: begin
                if (p.helm_mode == HM_DRIVE) begin
                    helm_fault = HF_NONE;
                    sup_state  = ST_STANDBY;
                end
            end
            ST_LINK_ERR: begin
                // an error state with no code recorded stays put
                if ((link_fault == LF_NOT_CONNECTED && p.vehicle_mode != VM_NOT_CONNECTED) ||
                    (link_fault == LF_NO_DATA && p.data_present)) begin
                    link_fault = LF_NONE;
                    sup_state  = ST_STANDBY;
                end
            end
            default: sup_state = ST_STANDBY;
        endcase
        r.state      = sup_state;
        r.changed    = (sup_state != prior);
        r.helm_fault = helm_fault;
        r.link_fault = link_fault;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sup_state  = ST_STANDBY;
            helm_fault = HF_NONE;
            link_fault = LF_NONE;
            regs.helm_required        = RstHelmRequired;
            regs.helm_timeout_seconds = RstHelmTimeout;
            regs.link_timeout_seconds = RstLinkTimeout;
            expected_status.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_HELM_REQUIRED: regs.helm_required        = i_cfg_data[0];
                    CFG_HELM_TIMEOUT:  regs.helm_timeout_seconds = i_cfg_data;
                    CFG_LINK_TIMEOUT:  regs.link_timeout_seconds = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_status.size() == 0) begin
                    $error("status item 0x%02h arrived with no poll outstanding",
                           i_m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("supervisor_state", want.state, i_m_axis_tdata[2:0]);
                    check_field("state_changed", want.changed, i_m_axis_tdata[3]);
                    check_field("helm_fault", want.helm_fault, i_m_axis_tdata[5:4]);
                    check_field("link_fault", want.link_fault, i_m_axis_tdata[7:6]);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_status.push_back(step_supervisor(t_item'(i_s_axis_tdata[20:0])));
        end
        o_outstanding = expected_status.size();
        o_failures    = fail_count;
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the vehicle interface supervisor
// Drives a directed poll sequence, then random phases under several register
// settings, with random gaps on the poll side and random stalls on the status
// side. Checking is done by vis_checker; this module only drives and reports.
// ----------------------------------------------------------------------------
module tb_top;
    import vis_pkg::*;

    // helm code outside the defined set
    localparam logic [1:0] HM_UNDEFINED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutDataW-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [CfgDatW-1:0]   cfg_data = '0;
    int                   outstanding;
    int                   failures;

    logic [SecsW-1:0]     helm_to = RstHelmTimeout;
    logic [SecsW-1:0]     link_to = RstLinkTimeout;
    logic                 helm_req = RstHelmRequired;
    bit                   no_gaps = 1'b0;
    bit                   no_stalls = 1'b0;
    int                   polls_sent = 0;

    vehicle_interface_supervisor u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    vis_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_outstanding   (outstanding),
        .o_failures      (failures)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("vehicle_interface_supervisor test failed");
        $finish;
    end

    function automatic t_item poll(input logic [1:0] helm, input logic [1:0] veh,
                                   input logic data, input logic [SecsW-1:0] secs);
        t_item p;
        p.helm_mode       = helm;
        p.vehicle_mode    = veh;
        p.data_present    = data;
        p.elapsed_seconds = secs;
        return p;
    endfunction

    // mostly around the timeouts, where the strict compare matters
    function automatic logic [SecsW-1:0] pick_seconds();
        case ($urandom_range(0, 8))
            0:       return '0;
            1:       return '1;
            2:       return helm_to;
            3:       return helm_to + 1'b1;
            4:       return link_to;
            5:       return link_to + 1'b1;
            6:       return helm_to - 1'b1;
            7:       return SecsW'($urandom_range(0, 20));
            default: return SecsW'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [1:0] random_helm();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return HM_DRIVE;
        if (r < 75) return HM_NOT_RUNNING;
        if (r < 88) return HM_PARK;
        return HM_UNDEFINED;
    endfunction

    task automatic send_poll(input t_item p);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, p};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        polls_sent++;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CfgDatW-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // clean standby -> listen -> command walk with the odd fault mixed in
    task automatic clean_episode();
        int unsigned hold;
        logic [1:0]  helm;
        helm = helm_req ? HM_DRIVE : random_helm();
        if (helm == HM_PARK) helm = HM_DRIVE;
        send_poll(poll(HM_DRIVE, 2'($urandom_range(1, 3)), 1'b1, pick_seconds()));
        send_poll(poll(helm, VM_ACCEPTING, 1'b1, pick_seconds()));
        hold = $urandom_range(1, 6);
        repeat (hold) begin
            if ($urandom_range(0, 7) == 0)
                send_poll(poll(random_helm(), 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), pick_seconds()));
            else
                send_poll(poll(HM_DRIVE,
                               ($urandom_range(0, 3) != 0) ? VM_ACCEPTING : VM_IN_CONTROL,
                               1'b1, pick_seconds()));
        end
        // drive, idle and data clear any error back to standby
        send_poll(poll(HM_DRIVE, VM_IDLE, 1'b1, pick_seconds()));
    endtask

    task automatic run_phase(input logic req, input logic [SecsW-1:0] hto,
                             input logic [SecsW-1:0] lto, input int n_polls);
        int unsigned burst;
        int          stop_at;
        write_reg(CFG_HELM_REQUIRED, {15'd0, req});
        write_reg(CFG_HELM_TIMEOUT, hto);
        write_reg(CFG_LINK_TIMEOUT, lto);
        helm_req = req;
        helm_to  = hto;
        link_to  = lto;
        stop_at  = polls_sent + n_polls;
        while (polls_sent < stop_at) begin
            if ($urandom_range(0, 6) == 0) no_gaps = ~no_gaps;
            if ($urandom_range(0, 9) < 7) begin
                clean_episode();
            end else begin
                burst = $urandom_range(1, 5);
                repeat (burst)
                    send_poll(poll(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                   1'($urandom_range(0, 1)), pick_seconds()));
            end
        end
        drain();
    endtask

    // status side: random stalls, with stall-free stretches
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0) no_stalls = ~no_stalls;
            stall = no_stalls ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready = 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed walk under reset register values
        send_poll(poll(HM_NOT_RUNNING, VM_NOT_CONNECTED, 1'b0, 16'd0));
        send_poll(poll(HM_NOT_RUNNING, VM_NOT_CONNECTED, 1'b0, 16'd10));
        send_poll(poll(HM_NOT_RUNNING, VM_IDLE, 1'b0, 16'd11));
        send_poll(poll(HM_UNDEFINED, VM_IDLE, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_IDLE, 1'b0, 16'd0));
        send_poll(poll(HM_DRIVE, VM_NOT_CONNECTED, 1'b0, 16'd11));
        send_poll(poll(HM_DRIVE, VM_NOT_CONNECTED, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_IDLE, 1'b0, 16'd0));
        send_poll(poll(HM_DRIVE, VM_IDLE, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_IDLE, 1'b0, 16'd0));
        send_poll(poll(HM_DRIVE, VM_IDLE, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_ACCEPTING, 1'b1, 16'hFFFF));
        send_poll(poll(HM_UNDEFINED, VM_ACCEPTING, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_ACCEPTING, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_ACCEPTING, 1'b1, 16'd0));
        send_poll(poll(HM_NOT_RUNNING, VM_ACCEPTING, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_ACCEPTING, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_IN_CONTROL, 1'b1, 16'd0));
        send_poll(poll(HM_PARK, VM_IDLE, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_IN_CONTROL, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_IN_CONTROL, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_ACCEPTING, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_NOT_CONNECTED, 1'b1, 16'd0));
        send_poll(poll(HM_DRIVE, VM_IN_CONTROL, 1'b0, 16'd0));
        send_poll(poll(HM_PARK, VM_NOT_CONNECTED, 1'b0, 16'hFFFF));
        drain();

        run_phase(1'b1, 16'd10, 16'd10, 105);
        run_phase(1'b0, 16'd0, 16'd0, 105);
        run_phase(1'b1, 16'hFFFF, 16'hFFFF, 105);
        run_phase(1'b1, 16'd0, 16'd0, 105);
        run_phase(1'b0, 16'hFFFF, SecsW'($urandom_range(1, 65534)), 105);
        run_phase(1'b1, SecsW'($urandom_range(0, 65535)),
                  SecsW'($urandom_range(0, 65535)), 105);

        repeat (8) @(negedge i_clk);
        if (failures == 0)
            $display("vehicle_interface_supervisor test passed");
        else
            $display("vehicle_interface_supervisor test failed");
        $finish;
    end

endmodule

>>> filelist.f
src/vis_pkg.sv
src/vis_step.sv
src/vehicle_interface_supervisor.sv
sim/vis_checker.sv
sim/tb_top.sv
